// ----- rtl/dst_pkg.sv -----
// Package for the device slot table: widths, codes and state type.
// No dependencies; used by device_slot_table_unit.
`timescale 1ns / 1ps

package dst_pkg;

	localparam int DEF_MAX_SLOTS = 8;

	localparam int ADDR_W  = 8;
	localparam int ITF_W   = 8;
	localparam int VID_W   = 16;
	localparam int PID_W   = 16;
	localparam int SEL_W   = 3;
	localparam int SLOT_OW = 3;
	localparam int CNT_W   = 32;
	localparam int ENTRY_W = ADDR_W + ITF_W + VID_W + PID_W;

	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 120;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_FIND   = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_MISS = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DONE
	} fsm_t;

endpackage

// ----- rtl/device_slot_table_unit.sv -----
// Device slot table: first-free slot allocator with lookup by bus address.
// Depends on dst_pkg for widths, codes and the sequencer state type.
`timescale 1ns / 1ps
//
// channel  dir  tdata (low bit up)                                   tuser
// s        in   device_address, interface_number, vendor_id,          kind
//               product_id, slot_index
// m        out  slot, slot_address, slot_interface, slot_vendor,      status
//               slot_product, slot_connected, mounted_total, unmounted_total
//
// One item at a time. Add takes the first free slot below the mark, else
// appends at the mark; remove and find scan for the address; read reads
// one slot. The scan visits one slot per cycle, for remove and find through
// the single read port of the entry memory. Reset clears the connected bits,
// the mark and both counters at once; no clearing pass. A result waits in
// the output register while the next item is accepted and scanned.

module device_slot_table_unit #(
	parameter int MAX_SLOTS = dst_pkg::DEF_MAX_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// device_address[7:0], interface_number[15:8], vendor_id[31:16],
	// product_id[47:32], slot_index[50:48], zero fill
	input  logic [dst_pkg::S_DATA_W-1:0]  s_tdata,
	// kind[1:0]
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// slot[2:0], slot_address[10:3], slot_interface[18:11], slot_vendor[34:19],
	// slot_product[50:35], slot_connected[51], mounted_total[83:52],
	// unmounted_total[115:84], zero fill
	output logic [dst_pkg::M_DATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic [1:0]                    m_tuser
);

	localparam int HW_W   = $clog2(MAX_SLOTS + 1);
	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CMP_W  = HW_W + dst_pkg::SEL_W;

	dst_pkg::fsm_t state_q, state_d;

	dst_pkg::kind_t                 kind_q;
	logic [dst_pkg::ADDR_W-1:0]     addr_q;
	logic [dst_pkg::ITF_W-1:0]      itf_q;
	logic [dst_pkg::VID_W-1:0]      vid_q;
	logic [dst_pkg::PID_W-1:0]      pid_q;
	logic [dst_pkg::SEL_W-1:0]      sel_q;

	logic [MAX_SLOTS-1:0]           live_q;
	logic [HW_W-1:0]                hw_q;
	logic [dst_pkg::CNT_W-1:0]      mount_q;
	logic [dst_pkg::CNT_W-1:0]      unmount_q;
	logic [HW_W-1:0]                idx_q;

	logic [dst_pkg::ENTRY_W-1:0]    mem_q [MAX_SLOTS];
	logic [dst_pkg::ENTRY_W-1:0]    mem_rd_q;
	logic                           rd_vld_s1;
	logic [SLOT_W-1:0]              rd_idx_s1;

	dst_pkg::status_t               res_st_q;
	logic [SLOT_W-1:0]              res_idx_q;
	logic                           res_app_q;
	logic                           m_tvalid_q;
	logic [dst_pkg::M_DATA_W-1:0]   m_tdata_q;
	logic [1:0]                     m_tuser_q;

	logic                           accept;
	logic                           idx_lt_hw;
	logic                           live_at_idx;
	logic                           hw_full;
	logic                           sel_ok;
	logic [CMP_W-1:0]               sel_ext;
	logic [CMP_W-1:0]               hw_ext;
	logic                           hit;

	logic                           scan_done;
	dst_pkg::status_t               scan_st;
	logic [SLOT_W-1:0]              scan_pick;
	logic                           scan_app;
	logic                           scan_adv;

	logic                           mem_rd_en;
	logic [SLOT_W-1:0]              mem_rd_addr;
	logic                           load_out;
	logic                           add_ok;
	logic                           rem_ok;
	logic                           rd_ok;
	logic [SLOT_W+dst_pkg::SLOT_OW-1:0] slot_ext;

	assign accept      = s_tvalid && s_tready;
	assign idx_lt_hw   = idx_q < hw_q;
	assign live_at_idx = live_q[idx_q[SLOT_W-1:0]];
	assign hw_full     = hw_q == HW_W'(MAX_SLOTS);
	assign sel_ext     = {{HW_W{1'b0}}, sel_q};
	assign hw_ext      = {{dst_pkg::SEL_W{1'b0}}, hw_q};
	assign sel_ok      = sel_ext < hw_ext;
	assign hit         = rd_vld_s1 && live_q[rd_idx_s1]
	                     && (mem_rd_q[dst_pkg::ADDR_W-1:0] == addr_q);

	// scan decision for the current slot
	always_comb begin
		scan_done = 1'b0;
		scan_st   = dst_pkg::STAT_MISS;
		scan_pick = '0;
		scan_app  = 1'b0;
		scan_adv  = 1'b0;
		unique case (kind_q)
			dst_pkg::KIND_ADD: begin
				if (idx_lt_hw && !live_at_idx) begin
					scan_done = 1'b1;
					scan_st   = dst_pkg::STAT_OK;
					scan_pick = idx_q[SLOT_W-1:0];
				end else if (idx_lt_hw) begin
					scan_adv = 1'b1;
				end else if (!hw_full) begin
					scan_done = 1'b1;
					scan_st   = dst_pkg::STAT_OK;
					scan_pick = hw_q[SLOT_W-1:0];
					scan_app  = 1'b1;
				end else begin
					scan_done = 1'b1;
					scan_st   = dst_pkg::STAT_FULL;
				end
			end
			dst_pkg::KIND_REMOVE, dst_pkg::KIND_FIND: begin
				if (hit) begin
					scan_done = 1'b1;
					scan_st   = dst_pkg::STAT_OK;
					scan_pick = rd_idx_s1;
				end else if (!idx_lt_hw && !rd_vld_s1) begin
					scan_done = 1'b1;
				end else begin
					scan_adv = idx_lt_hw;
				end
			end
			dst_pkg::KIND_READ: begin
				scan_done = 1'b1;
				if (sel_ok) begin
					scan_st   = dst_pkg::STAT_OK;
					scan_pick = sel_ext[SLOT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dst_pkg::FSM_IDLE: if (accept) state_d = dst_pkg::FSM_SCAN;
			dst_pkg::FSM_SCAN: if (scan_done) state_d = dst_pkg::FSM_DONE;
			dst_pkg::FSM_DONE: if (load_out) state_d = dst_pkg::FSM_IDLE;
			default: state_d = dst_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = state_q == dst_pkg::FSM_IDLE;
		mem_rd_en   = 1'b0;
		mem_rd_addr = idx_q[SLOT_W-1:0];
		if (state_q == dst_pkg::FSM_SCAN) begin
			if (kind_q == dst_pkg::KIND_READ) begin
				mem_rd_en   = sel_ok;
				mem_rd_addr = sel_ext[SLOT_W-1:0];
			end else if (kind_q != dst_pkg::KIND_ADD) begin
				mem_rd_en = scan_adv && !hit;
			end
		end
		load_out = (state_q == dst_pkg::FSM_DONE) && (!m_tvalid_q || m_tready);
		add_ok   = load_out && (kind_q == dst_pkg::KIND_ADD)
		           && (res_st_q == dst_pkg::STAT_OK);
		rem_ok   = load_out && (kind_q == dst_pkg::KIND_REMOVE)
		           && (res_st_q == dst_pkg::STAT_OK);
		rd_ok    = (kind_q == dst_pkg::KIND_READ) && (res_st_q == dst_pkg::STAT_OK);
		slot_ext = {{dst_pkg::SLOT_OW{1'b0}}, res_idx_q};
	end

	always_ff @(posedge clk) begin
		if (mem_rd_en) begin
			mem_rd_q <= mem_q[mem_rd_addr];
		end
		if (add_ok) begin
			mem_q[res_idx_q] <= {pid_q, vid_q, itf_q, addr_q};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= dst_pkg::kind_t'(s_tuser);
			addr_q <= s_tdata[7:0];
			itf_q  <= s_tdata[15:8];
			vid_q  <= s_tdata[31:16];
			pid_q  <= s_tdata[47:32];
			sel_q  <= s_tdata[50:48];
		end
		if (mem_rd_en) begin
			rd_idx_s1 <= mem_rd_addr;
		end
		if (state_q == dst_pkg::FSM_SCAN && scan_done) begin
			res_st_q  <= scan_st;
			res_idx_q <= scan_pick;
			res_app_q <= scan_app;
		end
		if (load_out) begin
			m_tuser_q <= res_st_q;
			m_tdata_q <= {4'b0,
				rem_ok ? unmount_q + dst_pkg::CNT_W'(1) : unmount_q,
				add_ok ? mount_q + dst_pkg::CNT_W'(1) : mount_q,
				rd_ok & live_q[res_idx_q],
				rd_ok ? mem_rd_q : {dst_pkg::ENTRY_W{1'b0}},
				slot_ext[dst_pkg::SLOT_OW-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dst_pkg::FSM_IDLE;
			live_q     <= '0;
			hw_q       <= '0;
			mount_q    <= '0;
			unmount_q  <= '0;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= '0;
			end else if (state_q == dst_pkg::FSM_SCAN && scan_adv && !hit) begin
				idx_q <= idx_q + HW_W'(1);
			end
			rd_vld_s1 <= mem_rd_en && (kind_q != dst_pkg::KIND_READ);
			if (add_ok) begin
				live_q[res_idx_q] <= 1'b1;
				mount_q           <= mount_q + dst_pkg::CNT_W'(1);
				if (res_app_q) begin
					hw_q <= hw_q + HW_W'(1);
				end
			end
			if (rem_ok) begin
				live_q[res_idx_q] <= 1'b0;
				unmount_q         <= unmount_q + dst_pkg::CNT_W'(1);
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
